### rtl/csds_pkg.sv
`timescale 1ns / 1ps
// csds_pkg: shared types and constants of the compressed-stream dfa scanner
// depends on nothing; every rtl file but csds_ram refers to it by scoped names

package csds_pkg;

  // defaults for the top-level parameters
  localparam int STATE_BITS_DEF     = 10;
  localparam int WINDOW_DEPTH_DEF   = 32768;
  localparam int MAX_REF_LENGTH_DEF = 258;

  // fixed port field widths
  localparam int FIELD_STATE_W   = 10;
  localparam int BYTE_W          = 8;
  localparam int COUNT_W         = 32;
  // widest history address that any legal window depth needs
  localparam int HIST_ADDR_MAX_W = 16;

  // queue depths
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;

  typedef enum logic [1:0] {
    ACT_SCAN         = 2'd0,
    ACT_WRITE_NEXT   = 2'd1,
    ACT_WRITE_ACCEPT = 2'd2,
    ACT_RESTART      = 2'd3
  } action_t;

  // classified item, front to back
  typedef struct packed {
    action_t                      action;
    logic [BYTE_W-1:0]            text_byte;
    logic [FIELD_STATE_W-1:0]     table_state;
    logic [FIELD_STATE_W-1:0]     table_next;
    logic                         accept_value;
    logic                         new_ref;      // byte opens a back-reference
    logic                         active;       // inside a usable back-reference
    logic                         before_zero;  // referenced byte is the first of the text
    logic                         last;         // final byte of the reference
    logic [HIST_ADDR_MAX_W-1:0]   wr_addr;      // history slot of this byte
    logic [HIST_ADDR_MAX_W-1:0]   src_addr;     // history slot of the referenced byte
    logic [HIST_ADDR_MAX_W-1:0]   prev_addr;    // history slot just before it
  } cmd_t;

  // result item
  typedef struct packed {
    logic [FIELD_STATE_W-1:0] dfa_state;
    logic                     accepting;
    logic                     was_scanned;
    logic [COUNT_W-1:0]       scan_total;
    logic [COUNT_W-1:0]       match_total;
  } out_item_t;

endpackage

### rtl/compressed_stream_dfa_scanner_top.sv
`timescale 1ns / 1ps
// compressed_stream_dfa_scanner_top: dfa scanner over lz77-decoded text
// depends on csds_pkg, csds_front, csds_queue, csds_back
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in_     | input     | in_valid / in_ready  | action, text_byte, ref_length,
//          |           |                      | ref_distance, table_state, table_next,
//          |           |                      | accept_value
//  out_    | output    | out_valid/out_ready  | dfa_state, accepting, was_scanned,
//          |           |                      | scan_total, match_total
//
// one item per cycle sustained while nothing stalls: each scan byte, table write or
// restart takes one issue slot in the back end; the limiting loop is transition ram
// registered read -> next state -> next transition address. a scan byte passes the
// command queue, execute stage, accept stage and result queue from in_ to out_.
// reset clears control state only; the transition, accept and history rams are
// not swept, so the block takes items as soon as reset is released.
// out_ready low fills a four-entry result queue; the back end stops issuing scan
// bytes once every free slot is claimed, then the four-entry command queue fills
// and in_ready drops.

module compressed_stream_dfa_scanner_top #(
  parameter int STATE_BITS     = csds_pkg::STATE_BITS_DEF,
  parameter int WINDOW_DEPTH   = csds_pkg::WINDOW_DEPTH_DEF,
  parameter int MAX_REF_LENGTH = csds_pkg::MAX_REF_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_action,
  input  logic [csds_pkg::BYTE_W-1:0]         in_text_byte,
  input  logic [8:0]                          in_ref_length,
  input  logic [15:0]                         in_ref_distance,
  input  logic [csds_pkg::FIELD_STATE_W-1:0]  in_table_state,
  input  logic [csds_pkg::FIELD_STATE_W-1:0]  in_table_next,
  input  logic                                in_accept_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [csds_pkg::FIELD_STATE_W-1:0]  out_dfa_state,
  output logic                                out_accepting,
  output logic                                out_was_scanned,
  output logic [csds_pkg::COUNT_W-1:0]        out_scan_total,
  output logic [csds_pkg::COUNT_W-1:0]        out_match_total
);

  // front -> command queue
  logic           fr_valid, fr_ready;
  csds_pkg::cmd_t fr_cmd;
  // command queue -> back
  logic           bk_valid, bk_ready;
  csds_pkg::cmd_t bk_cmd;
  csds_pkg::out_item_t out_item;

  // front: reference bookkeeping and history slot arithmetic, known ahead of
  // any dfa state, so it runs decoupled from the back end
  csds_front #(
    .WINDOW_DEPTH   (WINDOW_DEPTH),
    .MAX_REF_LENGTH (MAX_REF_LENGTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_text_byte    (in_text_byte),
    .in_ref_length   (in_ref_length),
    .in_ref_distance (in_ref_distance),
    .in_table_state  (in_table_state),
    .in_table_next   (in_table_next),
    .in_accept_value (in_accept_value),
    .cmd_valid       (fr_valid),
    .cmd_ready       (fr_ready),
    .cmd             (fr_cmd)
  );

  // short queue so front and back stall independently
  csds_queue #(
    .WIDTH ($bits(csds_pkg::cmd_t)),
    .DEPTH (csds_pkg::CMDQ_DEPTH)
  ) u_cmd_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_cmd),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_cmd),
    .count      ()
  );

  // back: issue, execute (table step or history copy), accept lookup, results
  csds_back #(
    .STATE_BITS   (STATE_BITS),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (bk_valid),
    .cmd_ready (bk_ready),
    .cmd       (bk_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // result fields onto their ports
  assign out_dfa_state   = out_item.dfa_state;
  assign out_accepting   = out_item.accepting;
  assign out_was_scanned = out_item.was_scanned;
  assign out_scan_total  = out_item.scan_total;
  assign out_match_total = out_item.match_total;

endmodule

### rtl/csds_ram.sv
`timescale 1ns / 1ps
// csds_ram: generic single-write, single-read ram with registered read data
// depends on nothing

module csds_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/csds_queue.sv
`timescale 1ns / 1ps
// csds_queue: small register-based fifo with valid/ready on both sides
// depends on csds_pkg for the default depth

module csds_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = csds_pkg::CMDQ_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push_valid,
  output logic                         push_ready,
  input  logic [WIDTH-1:0]             push_data,
  output logic                         pop_valid,
  input  logic                         pop_ready,
  output logic [WIDTH-1:0]             pop_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign count      = count_r;

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/csds_front.sv
`timescale 1ns / 1ps
// csds_front: accepts input items, tracks text position and back-reference
// bookkeeping, and hands classified items to the command queue; uses csds_pkg

module csds_front #(
  parameter int WINDOW_DEPTH   = csds_pkg::WINDOW_DEPTH_DEF,
  parameter int MAX_REF_LENGTH = csds_pkg::MAX_REF_LENGTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_action,
  input  logic [csds_pkg::BYTE_W-1:0]           in_text_byte,
  input  logic [8:0]                            in_ref_length,
  input  logic [15:0]                           in_ref_distance,
  input  logic [csds_pkg::FIELD_STATE_W-1:0]    in_table_state,
  input  logic [csds_pkg::FIELD_STATE_W-1:0]    in_table_next,
  input  logic                                  in_accept_value,
  output logic                                  cmd_valid,
  input  logic                                  cmd_ready,
  output csds_pkg::cmd_t                        cmd
);

  localparam int HA    = $clog2(WINDOW_DEPTH);
  localparam int REM_W = $clog2(MAX_REF_LENGTH + 1);
  localparam int LEN_W = (REM_W > 9) ? REM_W : 9;
  localparam int HMW   = csds_pkg::HIST_ADDR_MAX_W;
  localparam logic [HA:0]   WIN_EXT  = (HA + 1)'(WINDOW_DEPTH);
  localparam logic [HA-1:0] WIN_LAST = HA'(WINDOW_DEPTH - 1);

  logic [31:0]      tp_r, tp_nxt;
  logic [HA-1:0]    hp_r, hp_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [HA-1:0]    off_r, off_nxt;

  csds_pkg::action_t action;
  logic              take;
  logic              new_ref, dist_ok;
  logic [REM_W-1:0]  rem_load, rem_cur;
  logic [HA-1:0]     off_load, off_cur;
  logic [HA:0]       diff, src_ext;
  logic [HA-1:0]     src_addr, prev_addr;

  assign action    = csds_pkg::action_t'(in_action);
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign take      = in_valid && cmd_ready;

  // a reference start loads length and distance
  assign new_ref  = (in_ref_length != '0);
  assign dist_ok  = (in_ref_distance != '0) && (32'(in_ref_distance) <= tp_r) &&
                    ({1'b0, in_ref_distance} < 17'(WINDOW_DEPTH));
  assign rem_load = (LEN_W'(in_ref_length) > LEN_W'(MAX_REF_LENGTH)) ?
                    REM_W'(MAX_REF_LENGTH) : REM_W'(in_ref_length);
  assign off_load = dist_ok ? in_ref_distance[HA-1:0] : '0;
  assign rem_cur  = new_ref ? rem_load : rem_r;
  assign off_cur  = new_ref ? off_load : off_r;

  // history slots, modulo the window
  assign diff      = {1'b0, hp_r} - {1'b0, off_cur};
  assign src_ext   = diff[HA] ? diff + WIN_EXT : diff;
  assign src_addr  = src_ext[HA-1:0];
  assign prev_addr = (src_addr == '0) ? WIN_LAST : src_addr - HA'(1);

  always_comb begin
    cmd              = '0;
    cmd.action       = action;
    cmd.text_byte    = in_text_byte;
    cmd.table_state  = in_table_state;
    cmd.table_next   = in_table_next;
    cmd.accept_value = in_accept_value;
    cmd.new_ref      = new_ref;
    cmd.active       = (rem_cur != '0) && (off_cur != '0);
    cmd.before_zero  = (tp_r == 32'(off_cur));
    cmd.last         = (rem_cur == REM_W'(1));
    cmd.wr_addr      = HMW'(hp_r);
    cmd.src_addr     = HMW'(src_addr);
    cmd.prev_addr    = HMW'(prev_addr);
  end

  always_comb begin
    tp_nxt  = tp_r;
    hp_nxt  = hp_r;
    rem_nxt = rem_r;
    off_nxt = off_r;
    if (take) begin
      unique case (action)
        csds_pkg::ACT_SCAN: begin
          rem_nxt = (rem_cur != '0) ? rem_cur - REM_W'(1) : '0;
          off_nxt = off_cur;
          hp_nxt  = (hp_r == WIN_LAST) ? '0 : hp_r + HA'(1);
          tp_nxt  = (tp_r == '1) ? tp_r : tp_r + 32'd1;
        end
        csds_pkg::ACT_RESTART: begin
          rem_nxt = '0;
          off_nxt = '0;
          hp_nxt  = '0;
          tp_nxt  = '0;
        end
        csds_pkg::ACT_WRITE_NEXT, csds_pkg::ACT_WRITE_ACCEPT: begin
          rem_nxt = rem_r;
        end
        default: begin
          rem_nxt = rem_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r  <= '0;
      hp_r  <= '0;
      rem_r <= '0;
      off_r <= '0;
    end else begin
      tp_r  <= tp_nxt;
      hp_r  <= hp_nxt;
      rem_r <= rem_nxt;
      off_r <= off_nxt;
    end
  end

endmodule

### rtl/csds_back.sv
`timescale 1ns / 1ps
// csds_back: issues classified items, steps or copies the dfa state, looks up
// accept flags and keeps the counters; uses csds_pkg, csds_ram, csds_queue

module csds_back #(
  parameter int STATE_BITS   = csds_pkg::STATE_BITS_DEF,
  parameter int WINDOW_DEPTH = csds_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  csds_pkg::cmd_t         cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output csds_pkg::out_item_t    out_item
);

  localparam int SB  = STATE_BITS;
  localparam int HA  = $clog2(WINDOW_DEPTH);
  localparam int TA  = SB + csds_pkg::BYTE_W;
  localparam int FW  = csds_pkg::FIELD_STATE_W;
  localparam int XW  = (SB > FW) ? SB : FW;
  localparam int QCW = $clog2(csds_pkg::OUTQ_DEPTH + 1);
  localparam int FCW = QCW + 1;
  localparam int CW  = csds_pkg::COUNT_W;

  // control registers
  logic          e_v_r, e_v_nxt;
  logic          a_v_r, a_v_nxt;
  logic [SB-1:0] cur_state_r, cur_state_nxt;
  logic          copy_mode_r, copy_mode_nxt;
  logic [CW-1:0] scan_cnt_r, scan_cnt_nxt;
  logic [CW-1:0] match_cnt_r, match_cnt_nxt;

  // execute-stage payload
  logic          e_new_ref_r, e_active_r, e_before_zero_r, e_last_r;
  logic [HA-1:0] e_wr_addr_r;
  logic          fwd_a_r, fwd_b_r;

  // accept-stage payload
  logic [SB-1:0] a_state_r;
  logic          a_scanned_r;
  logic [CW-1:0] a_scan_r;

  logic           is_scan, fire, issue, restart_fire, tnext_fire, acc_fire;
  logic [QCW-1:0] oq_count;
  logic [FCW-1:0] in_flight;
  logic           credit_ok;
  logic [XW-1:0]  row_x, tnext_x, st_x;
  logic [SB-1:0]  row, tnext;
  logic [HA-1:0]  src_addr, prev_addr;
  logic [SB-1:0]  t_rdata, ha_rdata, hb_rdata, hist_a, hist_b, before_st, next_e;
  logic           acc_rdata;
  logic           cm_in, cm_mid, use_copy;
  logic [CW-1:0]  match_total;
  csds_pkg::out_item_t push_item;

  // scan bytes need a free output slot for themselves and every item already in flight
  assign in_flight = FCW'(e_v_r) + FCW'(a_v_r) + FCW'(oq_count);
  assign credit_ok = (in_flight < FCW'(csds_pkg::OUTQ_DEPTH));

  assign is_scan      = (cmd.action == csds_pkg::ACT_SCAN);
  assign cmd_ready    = !is_scan || credit_ok;
  assign fire         = cmd_valid && cmd_ready;
  assign issue        = fire && is_scan;
  assign restart_fire = fire && (cmd.action == csds_pkg::ACT_RESTART);
  assign tnext_fire   = fire && (cmd.action == csds_pkg::ACT_WRITE_NEXT);
  assign acc_fire     = fire && (cmd.action == csds_pkg::ACT_WRITE_ACCEPT);

  assign row_x     = XW'(cmd.table_state);
  assign row       = row_x[SB-1:0];
  assign tnext_x   = XW'(cmd.table_next);
  assign tnext     = tnext_x[SB-1:0];
  assign src_addr  = cmd.src_addr[HA-1:0];
  assign prev_addr = cmd.prev_addr[HA-1:0];

  // execute stage: pick copy or table step
  assign hist_a    = fwd_a_r ? cur_state_r : ha_rdata;
  assign hist_b    = fwd_b_r ? cur_state_r : hb_rdata;
  assign cm_in     = e_new_ref_r ? 1'b0 : copy_mode_r;
  assign before_st = e_before_zero_r ? '0 : hist_b;
  assign cm_mid    = cm_in || (e_active_r && (before_st == cur_state_r));
  assign use_copy  = e_active_r && cm_mid;
  assign next_e    = use_copy ? hist_a : t_rdata;

  always_comb begin
    e_v_nxt       = issue;
    a_v_nxt       = e_v_r;
    cur_state_nxt = cur_state_r;
    copy_mode_nxt = copy_mode_r;
    scan_cnt_nxt  = scan_cnt_r;
    if (e_v_r) begin
      cur_state_nxt = next_e;
      copy_mode_nxt = e_last_r ? 1'b0 : cm_mid;
      scan_cnt_nxt  = scan_cnt_r + CW'(!use_copy);
    end
    // restart is later in order than the byte in execute
    if (restart_fire) begin
      cur_state_nxt = '0;
      copy_mode_nxt = 1'b0;
    end
  end

  assign match_total   = match_cnt_r + CW'(acc_rdata);
  assign match_cnt_nxt = a_v_r ? match_total : match_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r       <= 1'b0;
      a_v_r       <= 1'b0;
      cur_state_r <= '0;
      copy_mode_r <= 1'b0;
      scan_cnt_r  <= '0;
      match_cnt_r <= '0;
    end else begin
      e_v_r       <= e_v_nxt;
      a_v_r       <= a_v_nxt;
      cur_state_r <= cur_state_nxt;
      copy_mode_r <= copy_mode_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      match_cnt_r <= match_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      e_new_ref_r     <= cmd.new_ref;
      e_active_r      <= cmd.active;
      e_before_zero_r <= cmd.before_zero;
      e_last_r        <= cmd.last;
      e_wr_addr_r     <= cmd.wr_addr[HA-1:0];
      // the byte in execute writes its slot this very cycle
      fwd_a_r         <= e_v_r && (src_addr == e_wr_addr_r);
      fwd_b_r         <= e_v_r && (prev_addr == e_wr_addr_r);
    end
    if (e_v_r) begin
      a_state_r   <= next_e;
      a_scanned_r <= !use_copy;
      a_scan_r    <= scan_cnt_nxt;
    end
  end

  csds_ram #(
    .WIDTH (SB),
    .DEPTH (1 << TA)
  ) u_trans_ram (
    .clk     (clk),
    .wr_en   (tnext_fire),
    .wr_addr ({row, cmd.text_byte}),
    .wr_data (tnext),
    .rd_addr ({cur_state_nxt, cmd.text_byte}),
    .rd_data (t_rdata)
  );

  csds_ram #(
    .WIDTH (SB),
    .DEPTH (WINDOW_DEPTH)
  ) u_hist_src_ram (
    .clk     (clk),
    .wr_en   (e_v_r),
    .wr_addr (e_wr_addr_r),
    .wr_data (next_e),
    .rd_addr (src_addr),
    .rd_data (ha_rdata)
  );

  csds_ram #(
    .WIDTH (SB),
    .DEPTH (WINDOW_DEPTH)
  ) u_hist_prev_ram (
    .clk     (clk),
    .wr_en   (e_v_r),
    .wr_addr (e_wr_addr_r),
    .wr_data (next_e),
    .rd_addr (prev_addr),
    .rd_data (hb_rdata)
  );

  csds_ram #(
    .WIDTH (1),
    .DEPTH (1 << SB)
  ) u_accept_ram (
    .clk     (clk),
    .wr_en   (acc_fire),
    .wr_addr (row),
    .wr_data (cmd.accept_value),
    .rd_addr (next_e),
    .rd_data (acc_rdata)
  );

  assign st_x = XW'(a_state_r);

  always_comb begin
    push_item             = '0;
    push_item.dfa_state   = st_x[FW-1:0];
    push_item.accepting   = acc_rdata;
    push_item.was_scanned = a_scanned_r;
    push_item.scan_total  = a_scan_r;
    push_item.match_total = match_total;
  end

  csds_queue #(
    .WIDTH ($bits(csds_pkg::out_item_t)),
    .DEPTH (csds_pkg::OUTQ_DEPTH)
  ) u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (a_v_r),
    .push_ready (),
    .push_data  (push_item),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_item),
    .count      (oq_count)
  );

endmodule

### rtl/csds_checker.sv
`timescale 1ns / 1ps
// csds_checker: port-level checks on the result channel of the scanner
// depends on csds_pkg; bound to compressed_stream_dfa_scanner_top below

module csds_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [csds_pkg::FIELD_STATE_W-1:0]  out_dfa_state,
  input logic                                out_accepting,
  input logic                                out_was_scanned,
  input logic [csds_pkg::COUNT_W-1:0]        out_scan_total,
  input logic [csds_pkg::COUNT_W-1:0]        out_match_total
);

  localparam int CW = csds_pkg::COUNT_W;

  logic          xfer;
  logic          have_prev_r;
  logic [CW-1:0] prev_scan_r, prev_match_r;
  logic [CW-1:0] exp_scan, exp_match;

  assign xfer      = out_valid && out_ready;
  assign exp_scan  = (have_prev_r ? prev_scan_r : '0) + CW'(out_was_scanned);
  assign exp_match = (have_prev_r ? prev_match_r : '0) + CW'(out_accepting);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      prev_scan_r  <= '0;
      prev_match_r <= '0;
    end else if (xfer) begin
      have_prev_r  <= 1'b1;
      prev_scan_r  <= out_scan_total;
      prev_match_r <= out_match_total;
    end
  end

  // no result left over from before reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // a stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dfa_state) &&
      $stable(out_accepting) && $stable(out_was_scanned) &&
      $stable(out_scan_total) && $stable(out_match_total))
    else $error("stalled result changed");

  // scan count advances exactly with table-stepped bytes
  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |-> out_scan_total == exp_scan)
    else $error("scan_total out of step with was_scanned");

  // match count advances exactly with accepting bytes
  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |-> out_match_total == exp_match)
    else $error("match_total out of step with accepting");

endmodule

bind compressed_stream_dfa_scanner_top csds_checker u_csds_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for compressed_stream_dfa_scanner_top
// depends on csds_pkg and the scanner rtl; runs directed and random text against a shadow dfa

module tb;

  localparam int WINDOW      = csds_pkg::WINDOW_DEPTH_DEF;
  localparam int MAX_REF     = csds_pkg::MAX_REF_LENGTH_DEF;
  localparam int HIST_W      = $clog2(WINDOW);
  localparam int NUM_LIVE    = 8;       // dfa states and alphabet bytes in use
  localparam int TEXT_CAP    = 3500;    // restart the text before the shadow buffer fills
  localparam int CYCLE_LIMIT = 400000;
  localparam int FSW         = csds_pkg::FIELD_STATE_W;
  localparam int BW          = csds_pkg::BYTE_W;

  // clock and reset
  logic clk;
  logic rst_n = 1'b0;

  // input channel, known values from time zero
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_action       = csds_pkg::ACT_SCAN;
  logic [BW-1:0]        in_text_byte    = '0;
  logic [8:0]           in_ref_length   = '0;
  logic [15:0]          in_ref_distance = '0;
  logic [FSW-1:0]       in_table_state  = '0;
  logic [FSW-1:0]       in_table_next   = '0;
  logic                 in_accept_value = 1'b0;

  // result channel
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [FSW-1:0]                  out_dfa_state;
  logic                            out_accepting;
  logic                            out_was_scanned;
  logic [csds_pkg::COUNT_W-1:0]    out_scan_total;
  logic [csds_pkg::COUNT_W-1:0]    out_match_total;

  int errors      = 0;
  int cycle_count = 0;
  bit idle_on     = 1'b1;   // random idling on both sides

  compressed_stream_dfa_scanner_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_text_byte    (in_text_byte),
    .in_ref_length   (in_ref_length),
    .in_ref_distance (in_ref_distance),
    .in_table_state  (in_table_state),
    .in_table_next   (in_table_next),
    .in_accept_value (in_accept_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dfa_state   (out_dfa_state),
    .out_accepting   (out_accepting),
    .out_was_scanned (out_was_scanned),
    .out_scan_total  (out_scan_total),
    .out_match_total (out_match_total)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the scanner: tables, history and per-text control state
  // ---------------------------------------------------------------------------
  logic [FSW-1:0] next_mem   [0:(1<<18)-1];  // {state, byte} -> next state
  logic           accept_mem [0:1023];
  logic [FSW-1:0] hist_mem   [0:WINDOW-1];   // state after each text byte

  logic [FSW-1:0]    cur_state = '0;
  logic [31:0]       text_pos  = '0;
  logic [HIST_W-1:0] hist_wr   = '0;
  logic              copying   = 1'b0;
  logic [8:0]        ref_left  = '0;
  logic [15:0]       ref_off   = '0;
  logic [31:0]       scan_cnt  = '0;
  logic [31:0]       match_cnt = '0;

  // results the scanner owes, oldest first
  csds_pkg::out_item_t pending_results[$];

  // stimulus side: the dfa states and bytes the table covers, and the decoded text so far
  logic [FSW-1:0] live_state [NUM_LIVE];
  logic [BW-1:0]  alpha      [NUM_LIVE];
  logic [BW-1:0]  text_mem   [0:4095];
  int             text_len = 0;

  // clock: 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[compressed_stream_dfa_scanner_top] ERROR");
      $finish;
    end
  end

  // update the shadow for one accepted transfer and queue the result it owes
  task automatic track_transfer(csds_pkg::action_t act, logic [7:0] txt, logic [8:0] len,
                                logic [15:0] ref_dist, logic [9:0] tstate,
                                logic [9:0] tnext, logic accv);
    logic [FSW-1:0]      nxt;
    logic [FSW-1:0]      before_st;
    logic                scanned;
    logic [HIST_W-1:0]   idx;
    csds_pkg::out_item_t res;
    case (act)
      csds_pkg::ACT_WRITE_NEXT: begin
        next_mem[{tstate, txt}] = tnext;
      end
      csds_pkg::ACT_WRITE_ACCEPT: begin
        accept_mem[tstate] = accv;
      end
      csds_pkg::ACT_RESTART: begin
        // counters and tables survive a new text
        cur_state = '0;
        text_pos  = '0;
        hist_wr   = '0;
        copying   = 1'b0;
        ref_left  = '0;
        ref_off   = '0;
      end
      default: begin
        // a nonzero length always opens a fresh reference
        if (len != 0) begin
          ref_left = (len > MAX_REF) ? 9'(MAX_REF) : len;
          copying  = 1'b0;
          ref_off  = (ref_dist != 0 && ref_dist <= text_pos && ref_dist < WINDOW) ?
                     ref_dist : 16'd0;
        end
        scanned = 1'b1;
        nxt     = '0;
        if (ref_left != 0 && ref_off != 0) begin
          // look for the point where our state matches the state before the source byte
          if (!copying) begin
            before_st = '0;   // position before the text counts as state 0
            if (text_pos != ref_off) begin
              idx       = hist_wr - ref_off[HIST_W-1:0] - 1'b1;
              before_st = hist_mem[idx];
            end
            if (before_st == cur_state) copying = 1'b1;
          end
          if (copying) begin
            idx     = hist_wr - ref_off[HIST_W-1:0];
            nxt     = hist_mem[idx];
            scanned = 1'b0;
          end
        end
        if (scanned) begin
          nxt = next_mem[{cur_state, txt}];
          scan_cnt++;
        end
        if (ref_left != 0) begin
          ref_left--;
          if (ref_left == 0) copying = 1'b0;
        end
        hist_mem[hist_wr] = nxt;
        hist_wr++;
        if (text_pos != '1) text_pos++;
        cur_state = nxt;
        if (accept_mem[nxt]) match_cnt++;   // copied and scanned bytes count alike
        res.dfa_state   = nxt;
        res.accepting   = accept_mem[nxt];
        res.was_scanned = scanned;
        res.scan_total  = scan_cnt;
        res.match_total = match_cnt;
        pending_results.push_back(res);
      end
    endcase
  endtask

  // one transfer on the input channel, with an occasional idle burst ahead of it
  task automatic send_item(csds_pkg::action_t act, logic [7:0] txt, logic [8:0] len,
                           logic [15:0] ref_dist, logic [9:0] tstate, logic [9:0] tnext,
                           logic accv);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_text_byte    <= txt;
    in_ref_length   <= len;
    in_ref_distance <= ref_dist;
    in_table_state  <= tstate;
    in_table_next   <= tnext;
    in_accept_value <= accv;
    do @(posedge clk); while (!in_ready);
    track_transfer(act, txt, len, ref_dist, tstate, tnext, accv);
  endtask

  // unused fields carry random values so every port bit moves
  task automatic send_scan(logic [7:0] txt, logic [8:0] len, logic [15:0] ref_dist);
    send_item(csds_pkg::ACT_SCAN, txt, len, ref_dist, 10'($urandom), 10'($urandom),
              1'($urandom));
    text_mem[text_len] = txt;
    text_len++;
  endtask

  task automatic send_restart();
    send_item(csds_pkg::ACT_RESTART, 8'($urandom), 9'($urandom), 16'($urandom),
              10'($urandom), 10'($urandom), 1'($urandom));
    text_len = 0;
  endtask

  task automatic write_next(logic [9:0] tstate, logic [7:0] txt, logic [9:0] tnext);
    send_item(csds_pkg::ACT_WRITE_NEXT, txt, 9'($urandom), 16'($urandom), tstate, tnext,
              1'($urandom));
  endtask

  task automatic write_accept(logic [9:0] tstate, logic accv);
    send_item(csds_pkg::ACT_WRITE_ACCEPT, 8'($urandom), 9'($urandom), 16'($urandom),
              tstate, 10'($urandom), accv);
  endtask

  function automatic bit is_live(logic [9:0] s);
    foreach (live_state[i]) if (live_state[i] == s) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit is_alpha(logic [7:0] b);
    foreach (alpha[i]) if (alpha[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] any_alpha();
    return alpha[$urandom_range(0, NUM_LIVE - 1)];
  endfunction

  function automatic logic [9:0] any_live();
    return live_state[$urandom_range(0, NUM_LIVE - 1)];
  endfunction

  task automatic send_literal();
    send_scan(any_alpha(), 9'd0, 16'($urandom));
  endtask

  // back-reference of len bytes, nsend sent; faithful copies unless garbled or out of the text
  task automatic send_reference(int ref_dist, int len, int nsend, bit garble);
    logic [7:0] txt;
    for (int i = 0; i < nsend; i++) begin
      if (!garble && ref_dist >= 1 && ref_dist <= text_len) txt = text_mem[text_len - ref_dist];
      else txt = any_alpha();
      if (i == 0) send_scan(txt, 9'(len), 16'(ref_dist));
      else send_scan(txt, 9'd0, 16'($urandom));
    end
  endtask

  // mostly short distances so the dfa resynchronizes quickly
  function automatic int pick_dist();
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, text_len);
    return $urandom_range(1, (text_len < 8) ? text_len : 8);
  endfunction

  // let the scanner drain everything owed
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // fill every table entry that a scan can reach; fresh picks new states and bytes
  task automatic load_dfa(bit fresh);
    logic [9:0] cand_st;
    logic [7:0] cand_b;
    if (fresh) begin
      // extreme and alternating bit patterns, the rest random
      foreach (live_state[i]) live_state[i] = '0;
      foreach (alpha[i]) alpha[i] = '0;
      live_state[1] = 10'h3FF;
      live_state[2] = 10'h155;
      live_state[3] = 10'h2AA;
      alpha[1]      = 8'hFF;
      alpha[2]      = 8'h55;
      alpha[3]      = 8'hAA;
      for (int i = 4; i < NUM_LIVE; i++) begin
        do cand_st = 10'($urandom); while (is_live(cand_st));
        live_state[i] = cand_st;
        do cand_b = 8'($urandom); while (is_alpha(cand_b));
        alpha[i] = cand_b;
      end
    end
    foreach (live_state[s])
      foreach (alpha[a])
        write_next(live_state[s], alpha[a], any_live());
    foreach (live_state[s])
      write_accept(live_state[s], (s == 1) ? 1'b1 : (s == 2) ? 1'b0 : ($urandom_range(0, 2) == 0));
  endtask

  // field extremes and each corner of the reference handling
  task automatic test_directed();
    send_restart();
    send_scan(8'h00, 9'd0, 16'd0);
    send_scan(8'hFF, 9'd0, 16'hFFFF);
    send_scan(8'h55, 9'd0, 16'd0);
    send_scan(8'hAA, 9'd0, 16'd0);
    send_literal();
    send_literal();
    // reference back to the first byte of the text: state before it is the start state
    send_reference(text_len, 4, 4, 1'b0);
    // unusable distances: zero, beyond the text, beyond the window
    send_reference(0, 3, 3, 1'b0);
    send_reference(text_len + 1, 3, 3, 1'b0);
    send_reference(16'hFFFF, 3, 3, 1'b0);
    // new reference cuts the previous one short
    send_reference(2, 10, 2, 1'b0);
    send_reference(3, 3, 3, 1'b0);
    // counters must survive a restart; distance equal to position right after it
    send_restart();
    send_literal();
    send_reference(1, 3, 3, 1'b0);
  endtask

  // length above the maximum is clipped: bytes past the clip get scanned again
  task automatic test_overlong_ref();
    send_restart();
    repeat (8) send_literal();
    send_reference(5, 511, MAX_REF + 4, 1'b0);
  endtask

  // mostly well-formed lz77 text, with noise, broken references and table rewrites
  task automatic test_random(int n_items);
    int         sent;
    int         r;
    int         len;
    int         ref_dist;
    int         k;
    logic [9:0] row;
    logic [9:0] nx;
    logic [7:0] txt;
    sent = 0;
    while (sent < n_items) begin
      if (text_len > TEXT_CAP) begin
        send_restart();
        sent++;
      end
      r = $urandom_range(0, 99);
      if (r < 35 || text_len == 0) begin
        k = $urandom_range(1, 4);
        repeat (k) send_literal();
        sent += k;
      end else if (r < 75) begin
        len = $urandom_range(3, 20);
        send_reference(pick_dist(), len, len, 1'b0);
        sent += len;
      end else if (r < 82) begin
        // abandoned before its end
        len = $urandom_range(4, 20);
        k   = $urandom_range(1, len - 1);
        send_reference(pick_dist(), len, k, 1'b0);
        sent += k;
      end else if (r < 87) begin
        case ($urandom_range(0, 2))
          0:       ref_dist = 0;
          1:       ref_dist = text_len + 1 + $urandom_range(0, 100);
          default: ref_dist = WINDOW + $urandom_range(0, WINDOW - 1);
        endcase
        len = $urandom_range(3, 10);
        send_reference(ref_dist, len, len, 1'($urandom));
        sent += len;
      end else if (r < 90) begin
        // content does not match the source bytes
        len = $urandom_range(3, 12);
        send_reference(pick_dist(), len, len, 1'b1);
        sent += len;
      end else if (r < 93) begin
        send_restart();
        sent++;
      end else if (r < 98) begin
        k = $urandom_range(1, 3);
        repeat (k) begin
          if ($urandom_range(0, 1) == 1) begin
            row = 10'($urandom);
            txt = 8'($urandom);
            nx  = 10'($urandom);
            // a reachable entry must keep pointing inside the live states
            if (is_live(row) && is_alpha(txt)) nx = any_live();
            write_next(row, txt, nx);
          end else begin
            write_accept(10'($urandom), 1'($urandom));
          end
        end
        sent += k;
      end else begin
        // overlong length, only a few bytes follow
        len = $urandom_range(MAX_REF + 1, 511);
        k   = $urandom_range(3, 12);
        send_reference(pick_dist(), len, k, 1'b0);
        sent += k;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, compare each transfer with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  initial begin : result_checker
    int                  stall_left;
    csds_pkg::out_item_t exp_res;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual dfa_state %0d", $time,
                   out_dfa_state);
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          check_field("dfa_state", exp_res.dfa_state, out_dfa_state);
          check_field("accepting", exp_res.accepting, out_accepting);
          check_field("was_scanned", exp_res.was_scanned, out_was_scanned);
          check_field("scan_total", exp_res.scan_total, out_scan_total);
          check_field("match_total", exp_res.match_total, out_match_total);
        end
      end
      // stall bursts of random length
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    // reset held from time zero, released before the first transfer
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_dfa(1'b1);
    test_directed();
    // sender holds off until the scanner has delivered everything
    wait_results_done();
    test_overlong_ref();
    test_random(90);
    wait_results_done();
    // new transition targets and accept flags over the same live states
    load_dfa(1'b0);
    test_random(75);
    // closing stretch at full rate on both sides
    idle_on = 1'b0;
    test_random(40);
    wait_results_done();
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("[compressed_stream_dfa_scanner_top] OK");
    end else begin
      $display("[compressed_stream_dfa_scanner_top] ERROR");
    end
    $finish;
  end

endmodule
